[rtl/core/ffra_pkg.sv]
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Request opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Register map, index = paddr / 4
    localparam int          PADDR_W     = 5;
    localparam logic [2:0] REG_POOL_BASE  = 3'd0;
    localparam logic [2:0] REG_POOL_BYTES = 3'd1;
    localparam logic [2:0] REG_PROT_BYTES = 3'd2;
    localparam logic [2:0] REG_RA_ALIGN   = 3'd3;
    localparam logic [2:0] REG_RA_ALLOWP  = 3'd4;

    localparam logic [31:0] PROTECTED_RESET = 32'd10485760;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] region_addr;
        logic [31:0] req_size;
        logic        prot_ok;
        logic [15:0] align;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic [31:0] copy_src;
        logic [31:0] copy_len;
    } t_out_item;

    // Configuration seen by the core; setup pulses the cycle after a pool write
    typedef struct packed {
        logic [31:0] pool_base;
        logic [31:0] pool_bytes;
        logic [31:0] protected_bytes;
        logic [15:0] realloc_align;
        logic        realloc_prot_ok;
        logic        setup;
    } t_cfg;

endpackage

[rtl/core/ffra_ram.sv]
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/ffra_rndup.sv]
// ----------------------------------------------------------------------------
// ffra_rndup
// Rounds an address up to a multiple of a 16-bit alignment. The remainder is
// found by a restoring divider, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ffra_rndup #(
    parameter int WW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_value,
    input  logic [15:0]   i_align,
    output logic          o_done,
    output logic [WW-1:0] o_value
);
    localparam int CW = $clog2(WW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [WW-1:0] r_val, n_val;
    logic [WW-1:0] r_src, n_src;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_align, n_align;
    logic [16:0]   rem_sh;

    // one restoring step per cycle
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_src   = r_src;
        n_rem   = r_rem;
        n_align = r_align;
        rem_sh  = {r_rem, r_val[WW-1]};
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CW'(WW);
            n_val   = i_value;
            n_src   = i_value;
            n_rem   = '0;
            n_align = i_align;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_align}) begin
                rem_sh = rem_sh - {1'b0, r_align};
            end
            n_rem = rem_sh[15:0];
            n_val = {r_val[WW-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val   <= n_val;
        r_src   <= n_src;
        r_rem   <= n_rem;
        r_align <= n_align;
    end

    assign o_done  = r_done;
    assign o_value = (r_rem == 16'd0) ? r_src : r_src + WW'(r_align - r_rem);
endmodule

[rtl/core/ffra_regs.sv]
// ----------------------------------------------------------------------------
// ffra_regs
// APB configuration registers; flags a pool set-up after a base or size write.
// ----------------------------------------------------------------------------
module ffra_regs import ffra_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    logic [31:0] r_pool_base, r_pool_bytes, r_prot_bytes;
    logic [15:0] r_ra_align;
    logic        r_ra_allowp;
    logic        r_setup;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_bytes <= '0;
            r_prot_bytes <= PROTECTED_RESET;
            r_ra_align   <= 16'd1;
            r_ra_allowp  <= 1'b0;
            r_setup      <= 1'b0;
        end else begin
            r_setup <= wr_en &&
                       (reg_idx == REG_POOL_BASE || reg_idx == REG_POOL_BYTES);
            if (wr_en) begin
                case (reg_idx)
                    REG_POOL_BASE:  r_pool_base  <= pwdata;
                    REG_POOL_BYTES: r_pool_bytes <= pwdata;
                    REG_PROT_BYTES: r_prot_bytes <= pwdata;
                    REG_RA_ALIGN:   r_ra_align   <= pwdata[15:0];
                    REG_RA_ALLOWP:  r_ra_allowp  <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_POOL_BASE:  prdata = r_pool_base;
            REG_POOL_BYTES: prdata = r_pool_bytes;
            REG_PROT_BYTES: prdata = r_prot_bytes;
            REG_RA_ALIGN:   prdata = {16'd0, r_ra_align};
            REG_RA_ALLOWP:  prdata = {31'd0, r_ra_allowp};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = '{pool_base: r_pool_base, pool_bytes: r_pool_bytes,
                     protected_bytes: r_prot_bytes, realloc_align: r_ra_align,
                     realloc_prot_ok: r_ra_allowp, setup: r_setup};
endmodule

[rtl/core/first_fit_region_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit allocator over a region table held in two RAMs (base, length),
// kept sorted by base. One request is handled at a time. A free searches the
// table for the base and closes the gap by moving later entries down; a
// reallocate searches the same way and resizes in place when it can. An
// allocation walks the regions in order, rounding each candidate up to the
// alignment with the bit-serial divider, then shifts entries up to insert;
// a moving reallocate follows this with a free of the old region. A new item
// is taken while the previous result waits in the output register. Writing
// pool_base or pool_bytes empties the table; no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top import ffra_pkg::*; #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int WW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
    localparam int IW = $clog2(MAX_REGIONS + 1);
    localparam int AI = $clog2(MAX_REGIONS);
    localparam logic [WW-1:0] AMASK = {{(WW - ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

    // search modes
    localparam logic [1:0] SM_FREE    = 2'd0;
    localparam logic [1:0] SM_REALLOC = 2'd1;
    localparam logic [1:0] SM_MOVE    = 2'd2;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001, S_SRD  = 18'h00002, S_SCK  = 18'h00004,
        S_GRD  = 18'h00008, S_GLD  = 18'h00010, S_GDEC = 18'h00020,
        S_AINIT= 18'h00040, S_ARND = 18'h00080, S_AWAIT= 18'h00100,
        S_ARD  = 18'h00200, S_ACK  = 18'h00400, S_AEND = 18'h00800,
        S_IRD  = 18'h01000, S_IWR  = 18'h02000, S_IPUT = 18'h04000,
        S_RRD  = 18'h08000, S_RWR  = 18'h10000, S_DONE = 18'h20000
    } t_state;

    t_cfg cfg;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_sh, n_sh;
    logic [31:0]   r_free, n_free;
    logic [WW-1:0] r_target, n_target;
    logic [31:0]   r_size, n_size;
    logic          r_allowp, n_allowp;
    logic [15:0]   r_align, n_align;
    logic [WW-1:0] r_pos, n_pos;
    logic [WW-1:0] r_floor, n_floor;
    logic [WW-1:0] r_old_s, n_old_s;
    logic [31:0]   r_old_n, n_old_n;
    logic [WW-1:0] r_room, n_room;
    logic [1:0]    r_mode, n_mode;
    logic          r_move, n_move;
    logic [31:0]   r_res, n_res;
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_src, n_src;
    logic [31:0]   r_len, n_len;
    t_out_item     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // memory ports
    logic                 we_s, we_l;
    logic [AI-1:0]        ram_waddr, ram_raddr;
    logic [ADDR_BITS-1:0] wstart, start_rd;
    logic [31:0]          wlen, len_rd;

    logic          div_start, div_done;
    logic [WW-1:0] div_value;

    logic [WW-1:0] base_w, pend_sum, pend_w, floor_w, start_x, len_x, end_x;
    logic [31:0]   usable;
    logic [IW-1:0] idx_p1, sh_p1, sh_m1;
    logic [32:0]   add_tmp;

    ffra_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    ffra_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_REGIONS)) u_start_ram (
        .i_clk(i_clk), .i_we(we_s), .i_waddr(ram_waddr), .i_wdata(wstart),
        .i_raddr(ram_raddr), .o_rdata(start_rd)
    );

    ffra_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS)) u_len_ram (
        .i_clk(i_clk), .i_we(we_l), .i_waddr(ram_waddr), .i_wdata(wlen),
        .i_raddr(ram_raddr), .o_rdata(len_rd)
    );

    ffra_rndup #(.WW(WW)) u_rndup (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_value(r_pos), .i_align(r_align), .o_done(div_done),
        .o_value(div_value)
    );

    // pool geometry and derived values
    assign base_w   = WW'(cfg.pool_base) & AMASK;
    assign pend_sum = base_w + WW'(cfg.pool_bytes);
    assign pend_w   = (pend_sum > AMASK) ? AMASK : pend_sum;
    assign floor_w  = base_w + (r_allowp ? '0 : WW'(cfg.protected_bytes));
    assign usable   = (r_allowp || r_free <= cfg.protected_bytes) ?
                      r_free : r_free - cfg.protected_bytes;
    assign start_x  = WW'(start_rd);
    assign len_x    = WW'(len_rd);
    assign end_x    = start_x + len_x;
    assign idx_p1   = r_idx + IW'(1);
    assign sh_p1    = r_sh + IW'(1);
    assign sh_m1    = r_sh - IW'(1);

    // request sequencer
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;       n_idx = r_idx;
        n_sh = r_sh;        n_free = r_free;     n_target = r_target;
        n_size = r_size;    n_allowp = r_allowp; n_align = r_align;
        n_pos = r_pos;      n_floor = r_floor;   n_old_s = r_old_s;
        n_old_n = r_old_n;  n_room = r_room;     n_mode = r_mode;
        n_move = r_move;    n_res = r_res;       n_st = r_st;
        n_src = r_src;      n_len = r_len;       n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        we_s = 1'b0;  we_l = 1'b0;
        ram_waddr = r_idx[AI-1:0];
        ram_raddr = r_idx[AI-1:0];
        wstart = start_rd;
        wlen   = len_rd;
        div_start = 1'b0;
        add_tmp = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '0;  n_st = ST_DONE;  n_src = '0;  n_len = '0;
                    n_size = i_in_item.req_size;
                    n_target = WW'(i_in_item.region_addr);
                    n_move = 1'b0;
                    n_idx = '0;
                    case (i_in_item.opcode)
                        OP_ALLOC: begin
                            n_allowp = i_in_item.prot_ok;
                            n_align = (i_in_item.align == 16'd0) ? 16'd1 : i_in_item.align;
                            n_state = S_AINIT;
                        end
                        OP_FREE: begin
                            n_mode = SM_FREE;
                            n_state = S_SRD;
                        end
                        OP_REALLOC: begin
                            if (i_in_item.region_addr == 32'd0) begin
                                n_allowp = cfg.realloc_prot_ok;
                                n_align = (cfg.realloc_align == 16'd0) ?
                                          16'd1 : cfg.realloc_align;
                                n_state = S_AINIT;
                            end else begin
                                n_mode = (i_in_item.req_size == 32'd0) ? SM_FREE : SM_REALLOC;
                                n_state = S_SRD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // search for an exact base
            S_SRD: begin
                if (r_idx < r_cnt) begin
                    n_state = S_SCK;
                end else if (r_mode == SM_REALLOC) begin
                    n_allowp = cfg.realloc_prot_ok;
                    n_align = (cfg.realloc_align == 16'd0) ? 16'd1 : cfg.realloc_align;
                    n_state = S_AINIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCK: begin
                if (start_x == r_target) begin
                    n_old_s = start_x;
                    n_old_n = len_rd;
                    if (r_mode == SM_REALLOC) begin
                        if (r_size <= len_rd) begin
                            // shrink in place
                            we_l = 1'b1;
                            wlen = r_size;
                            add_tmp = {1'b0, r_free} + {1'b0, len_rd - r_size};
                            n_free = add_tmp[32] ? 32'hFFFF_FFFF : add_tmp[31:0];
                            n_res = start_x[31:0];
                            n_state = S_DONE;
                        end else if (idx_p1 < r_cnt) begin
                            n_state = S_GRD;
                        end else begin
                            n_room = (pend_w > start_x) ? pend_w - start_x : '0;
                            n_state = S_GDEC;
                        end
                    end else begin
                        add_tmp = {1'b0, r_free} + {1'b0, len_rd};
                        n_free = add_tmp[32] ? 32'hFFFF_FFFF : add_tmp[31:0];
                        if (r_mode == SM_MOVE) begin
                            n_src = start_x[31:0];
                            n_len = len_rd;
                        end
                        n_sh = r_idx;
                        n_state = S_RRD;
                    end
                end else begin
                    n_idx = idx_p1;
                    n_state = S_SRD;
                end
            end
            // grow check against the next region
            S_GRD: begin
                ram_raddr = idx_p1[AI-1:0];
                n_state = S_GLD;
            end
            S_GLD: begin
                n_room = start_x - r_old_s;
                n_state = S_GDEC;
            end
            S_GDEC: begin
                if (r_room >= WW'(r_size)) begin
                    we_l = 1'b1;
                    wlen = r_size;
                    n_free = ((r_size - r_old_n) > r_free) ? '0 : r_free - (r_size - r_old_n);
                    n_res = r_old_s[31:0];
                    n_state = S_DONE;
                end else begin
                    n_move = 1'b1;
                    n_allowp = cfg.realloc_prot_ok;
                    n_align = (cfg.realloc_align == 16'd0) ? 16'd1 : cfg.realloc_align;
                    n_state = S_AINIT;
                end
            end
            // first-fit allocation
            S_AINIT: begin
                if (r_cnt >= IW'(MAX_REGIONS)) begin
                    n_st = ST_FULL;
                    n_state = S_DONE;
                end else if (r_size > usable) begin
                    n_st = ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    n_pos = floor_w;
                    n_floor = floor_w;
                    n_idx = '0;
                    n_state = S_ARND;
                end
            end
            S_ARND: begin
                div_start = 1'b1;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                if (div_done) begin
                    n_pos = div_value;
                    n_state = (r_idx < r_cnt) ? S_ARD : S_AEND;
                end
            end
            S_ARD: begin
                n_state = S_ACK;
            end
            S_ACK: begin
                if (r_pos + WW'(r_size) <= start_x) begin
                    n_sh = r_cnt;
                    n_state = S_IRD;
                end else begin
                    n_pos = (end_x < r_floor) ? r_floor : end_x;
                    n_idx = idx_p1;
                    n_state = S_ARND;
                end
            end
            S_AEND: begin
                if (r_pos + WW'(r_size) <= pend_w) begin
                    n_sh = r_cnt;
                    n_state = S_IRD;
                end else begin
                    n_st = ST_NOSPACE;
                    n_state = S_DONE;
                end
            end
            // open a slot at r_idx, moving entries up from the top
            S_IRD: begin
                ram_raddr = sh_m1[AI-1:0];
                n_state = (r_sh > r_idx) ? S_IWR : S_IPUT;
            end
            S_IWR: begin
                we_s = 1'b1;
                we_l = 1'b1;
                ram_waddr = r_sh[AI-1:0];
                n_sh = sh_m1;
                n_state = S_IRD;
            end
            S_IPUT: begin
                we_s = 1'b1;
                we_l = 1'b1;
                wstart = r_pos[ADDR_BITS-1:0];
                wlen = r_size;
                n_cnt = r_cnt + IW'(1);
                n_free = (r_size > r_free) ? '0 : r_free - r_size;
                n_res = r_pos[31:0];
                if (r_move) begin
                    n_mode = SM_MOVE;
                    n_target = r_old_s;
                    n_idx = '0;
                    n_state = S_SRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // close the gap at r_sh, moving entries down
            S_RRD: begin
                ram_raddr = sh_p1[AI-1:0];
                if (sh_p1 < r_cnt) begin
                    n_state = S_RWR;
                end else begin
                    n_cnt = r_cnt - IW'(1);
                    n_state = S_DONE;
                end
            end
            S_RWR: begin
                we_s = 1'b1;
                we_l = 1'b1;
                ram_waddr = r_sh[AI-1:0];
                n_sh = sh_p1;
                n_state = S_RRD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out = '{result_addr: r_res, status: r_st,
                              copy_src: r_src, copy_len: r_len};
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // pool set-up empties the table
        if (cfg.setup) begin
            n_cnt = '0;
            n_free = cfg.pool_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= SM_FREE;
            r_move      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_move      <= n_move;
        end
        r_idx    <= n_idx;
        r_sh     <= n_sh;
        r_target <= n_target;
        r_size   <= n_size;
        r_allowp <= n_allowp;
        r_align  <= n_align;
        r_pos    <= n_pos;
        r_floor  <= n_floor;
        r_old_s  <= n_old_s;
        r_old_n  <= n_old_n;
        r_room   <= n_room;
        r_res    <= n_res;
        r_st     <= n_st;
        r_src    <= n_src;
        r_len    <= n_len;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    // table never holds more regions than it has entries
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= IW'(MAX_REGIONS))
        else $error("region count above table depth");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");

    // a reported copy only comes with a granted address
    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.copy_len != 32'd0) |-> o_out_item.status == ST_DONE)
        else $error("copy reported on failed request");

    // status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_DONE ||
                         o_out_item.status == ST_NOSPACE ||
                         o_out_item.status == ST_FULL))
        else $error("undefined status code");
`endif
endmodule

[sim/tb_first_fit_region_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator_top
// Self-checking bench for the first-fit region allocator: a directed table of
// requests, then random allocate/free/reallocate traffic across several pool
// settings. Every result is compared with a behavioral copy of the allocator.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator_top;
    import ffra_pkg::*;

    localparam int NREG    = 64;
    localparam int N_RAND  = 970;
    localparam int SETTLE  = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    first_fit_region_allocator_top u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Allocator state mirror
    logic [63:0] m_base, m_bytes, m_prot, m_ra_align;
    logic        m_ra_allowp;
    logic [63:0] reg_start [NREG];
    logic [63:0] reg_len   [NREG];
    int          reg_cnt;
    logic [63:0] free_cnt;

    t_out_item   pending_results[$];
    int          n_errors = 0;
    int          n_accepted = 0;
    bit          quiet_phase = 1'b0;

    // Directed rows: item, whether a typed result applies, and that result
    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item res;
    } t_row;
    t_row rows[$];

    function automatic logic [63:0] pool_limit();
        logic [63:0] e;
        e = m_base + m_bytes;
        return (e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : e;
    endfunction

    function automatic void drop_bytes(logic [63:0] n);
        free_cnt = (n > free_cnt) ? 64'd0 : free_cnt - n;
    endfunction

    function automatic void return_bytes(logic [63:0] n);
        free_cnt = free_cnt + n;
        if (free_cnt > 64'hFFFF_FFFF) free_cnt = 64'hFFFF_FFFF;
    endfunction

    function automatic void place_region(int idx, logic [63:0] s, logic [63:0] n);
        for (int k = reg_cnt; k > idx; k--) begin
            reg_start[k] = reg_start[k-1];
            reg_len[k]   = reg_len[k-1];
        end
        reg_start[idx] = s;
        reg_len[idx]   = n;
        reg_cnt++;
        drop_bytes(n);
    endfunction

    function automatic logic [1:0] first_fit(logic [63:0] size, bit allowp,
                                             logic [63:0] al, output logic [63:0] got);
        logic [63:0] usable, flr, pos;
        got = 0;
        if (al == 0) al = 1;
        if (reg_cnt >= NREG) return ST_FULL;
        usable = (allowp || free_cnt <= m_prot) ? free_cnt : free_cnt - m_prot;
        if (size > usable) return ST_NOSPACE;
        flr = m_base + (allowp ? 64'd0 : m_prot);
        pos = flr;
        for (int k = 0; k < reg_cnt; k++) begin
            if (pos % al != 0) pos = (pos / al + 1) * al;
            if (pos + size <= reg_start[k]) begin
                place_region(k, pos, size);
                got = pos;
                return ST_DONE;
            end
            pos = reg_start[k] + reg_len[k];
            if (pos < flr) pos = flr;
        end
        if (pos % al != 0) pos = (pos / al + 1) * al;
        if (pos + size <= pool_limit()) begin
            place_region(reg_cnt, pos, size);
            got = pos;
            return ST_DONE;
        end
        return ST_NOSPACE;
    endfunction

    function automatic void release_region(logic [63:0] a);
        for (int k = 0; k < reg_cnt; k++) begin
            if (reg_start[k] == a) begin
                return_bytes(reg_len[k]);
                for (int j = k; j < reg_cnt - 1; j++) begin
                    reg_start[j] = reg_start[j+1];
                    reg_len[j]   = reg_len[j+1];
                end
                reg_cnt--;
                return;
            end
        end
    endfunction

    function automatic t_out_item predict_allocator(t_in_item it);
        t_out_item   r;
        logic [63:0] a, sz, got, room, e, old_s, old_n;
        logic [1:0]  st;
        int          k;
        r = '0;
        a = it.region_addr;
        sz = it.req_size;
        got = 0;
        st = ST_DONE;
        if (it.opcode == OP_ALLOC) begin
            st = first_fit(sz, it.prot_ok, it.align, got);
        end else if (it.opcode == OP_FREE) begin
            release_region(a);
        end else if (it.opcode == OP_REALLOC) begin
            k = reg_cnt;
            if (a != 0 && sz != 0) begin
                for (k = 0; k < reg_cnt; k++)
                    if (reg_start[k] == a) break;
            end
            if (a == 0 || (sz != 0 && k >= reg_cnt)) begin
                st = first_fit(sz, m_ra_allowp, m_ra_align, got);
            end else if (sz == 0) begin
                release_region(a);
            end else if (sz <= reg_len[k]) begin
                return_bytes(reg_len[k] - sz);
                reg_len[k] = sz;
                got = reg_start[k];
            end else begin
                e = pool_limit();
                if (k + 1 < reg_cnt) room = reg_start[k+1] - reg_start[k];
                else room = (e > reg_start[k]) ? e - reg_start[k] : 64'd0;
                if (room >= sz) begin
                    drop_bytes(sz - reg_len[k]);
                    reg_len[k] = sz;
                    got = reg_start[k];
                end else begin
                    old_s = reg_start[k];
                    old_n = reg_len[k];
                    st = first_fit(sz, m_ra_allowp, m_ra_align, got);
                    if (st == ST_DONE) begin
                        release_region(old_s);
                        r.copy_src = old_s[31:0];
                        r.copy_len = old_n[31:0];
                    end
                end
            end
        end
        r.result_addr = got[31:0];
        r.status = st;
        return r;
    endfunction

    // Register write through the APB port, mirrored into the model
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PADDR_W'({idx, 2'b00}); pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_POOL_BASE:  begin m_base = v; reg_cnt = 0; free_cnt = m_bytes; end
            REG_POOL_BYTES: begin m_bytes = v; reg_cnt = 0; free_cnt = m_bytes; end
            REG_PROT_BYTES: m_prot = v;
            REG_RA_ALIGN:   m_ra_align = v[15:0];
            REG_RA_ALLOWP:  m_ra_allowp = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Present one item and hold it until accepted; expectation queued at accept
    task automatic send_item(t_in_item it, bit fixed, t_out_item want);
        t_out_item p;
        @(negedge i_clk);
        while (!quiet_phase && $urandom_range(99) < 25) @(negedge i_clk);
        i_in_item = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_allocator(it);
        if (fixed && p != want) begin
            n_errors++;
            if (n_errors <= 10)
                $display("directed row mismatch: typed %h model %h", want, p);
        end
        pending_results = {pending_results, p};
        n_accepted++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Result side: random stalls, compare at accept
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.result_addr !== want.result_addr ||
                    o_out_item.status !== want.status ||
                    o_out_item.copy_src !== want.copy_src ||
                    o_out_item.copy_len !== want.copy_len) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp addr %h st %0d src %h len %h, got addr %h st %0d src %h len %h",
                                 want.result_addr, want.status, want.copy_src, want.copy_len,
                                 o_out_item.result_addr, o_out_item.status,
                                 o_out_item.copy_src, o_out_item.copy_len);
                end
            end
        end
    end

    function automatic t_in_item mk(logic [1:0] op, logic [31:0] a, logic [31:0] s,
                                    bit ap, logic [15:0] al);
        t_in_item it;
        it.opcode = op; it.region_addr = a; it.req_size = s;
        it.prot_ok = ap; it.align = al;
        return it;
    endfunction

    function automatic t_out_item res(logic [31:0] a, logic [1:0] st);
        t_out_item r;
        r = '0; r.result_addr = a; r.status = st;
        return r;
    endfunction

    function automatic void add_row(t_in_item it, bit fixed, t_out_item r);
        t_row w;
        w.item = it; w.fixed = fixed; w.res = r;
        rows = {rows, w};
    endfunction

    // Random request biased toward live bases and small sizes
    function automatic t_in_item random_request(int span);
        t_in_item    it;
        logic [31:0] a;
        int          pick;
        it = '0;
        pick = $urandom_range(99);
        it.opcode = (pick < 45) ? OP_ALLOC : (pick < 70) ? OP_FREE :
                    (pick < 97) ? OP_REALLOC : OP_NOP;
        if (reg_cnt > 0 && $urandom_range(9) < 8)
            a = reg_start[$urandom_range(reg_cnt - 1)][31:0];
        else if ($urandom_range(9) == 0) a = 32'd0;
        else a = $urandom;
        it.region_addr = a;
        case ($urandom_range(9))
            0:       it.req_size = $urandom;
            1:       it.req_size = 32'd0;
            default: it.req_size = $urandom_range(span);
        endcase
        it.prot_ok = $urandom_range(1);
        case ($urandom_range(5))
            0:       it.align = $urandom;
            1:       it.align = 16'd0;
            default: it.align = $urandom_range(64, 1);
        endcase
        return it;
    endfunction

    initial begin
        t_in_item it;
        m_base = 0; m_bytes = 0; m_prot = PROTECTED_RESET;
        m_ra_align = 1; m_ra_allowp = 0; reg_cnt = 0; free_cnt = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty pool after reset: a one-byte allocation finds no room, a zero-size one succeeds, free is a no-op
        add_row(mk(OP_ALLOC, 32'd0, 32'd1, 1'b1, 16'd1), 1, res(0, ST_NOSPACE));
        add_row(mk(OP_ALLOC, 32'd0, 32'd0, 1'b1, 16'd0), 1, res(0, ST_DONE));
        add_row(mk(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'hFFFF), 1, res(0, ST_DONE));
        add_row(mk(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF), 1, res(0, ST_DONE));
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);
        rows.delete();
        wait_drained();

        // Small pool above a protected floor
        write_reg(REG_POOL_BASE, 32'h0000_1000);
        write_reg(REG_POOL_BYTES, 32'd4096);
        write_reg(REG_PROT_BYTES, 32'd1024);
        write_reg(REG_RA_ALIGN, 16'd16);
        write_reg(REG_RA_ALLOWP, 32'd1);
        add_row(mk(OP_ALLOC, 0, 32'd100, 1'b0, 16'd1), 1, res(32'h1400, ST_DONE));
        add_row(mk(OP_ALLOC, 0, 32'd100, 1'b1, 16'd7), 1, res(32'h1006, ST_DONE));
        add_row(mk(OP_ALLOC, 0, 32'd3000, 1'b0, 16'd1), 1, res(0, ST_NOSPACE));
        add_row(mk(OP_ALLOC, 0, 32'd50, 1'b0, 16'hFFFF), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1400, 32'd40, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1400, 32'd200, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1006, 32'd500, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'd0, 32'd30, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1234, 32'd30, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1400, 32'd0, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_FREE, 32'h1400, 0, 1'b0, 16'd1), 0, '0);
        add_row(mk(OP_REALLOC, 32'h1006, 32'hFFFF_FFFF, 1'b0, 16'd1), 0, '0);
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);
        rows.delete();
        wait_drained();

        // Pool end saturates at the top of the address space; fill the table
        write_reg(REG_POOL_BASE, 32'hFFFF_F000);
        write_reg(REG_POOL_BYTES, 32'hFFFF_FFFF);
        write_reg(REG_PROT_BYTES, 32'd0);
        for (int i = 0; i < NREG; i++)
            send_item(mk(OP_ALLOC, 0, 32'd8, 1'b0, 16'd1), 0, '0);
        send_item(mk(OP_ALLOC, 0, 32'd1, 1'b1, 16'd1), 1, res(0, ST_FULL));
        wait_drained();

        // Random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            int span;
            case (ph)
                0: begin write_reg(REG_POOL_BASE, 32'h0); write_reg(REG_POOL_BYTES, 32'd4096);
                         write_reg(REG_PROT_BYTES, 32'd512); span = 600; end
                1: begin write_reg(REG_POOL_BASE, $urandom); write_reg(REG_POOL_BYTES, 32'd2000);
                         write_reg(REG_PROT_BYTES, 32'd0); write_reg(REG_RA_ALIGN, 16'hFFFF);
                         write_reg(REG_RA_ALLOWP, 32'd0); span = 200; end
                2: begin write_reg(REG_POOL_BASE, 32'h8000_0000); write_reg(REG_POOL_BYTES, 32'hFFFF_FFFF);
                         write_reg(REG_PROT_BYTES, 32'hFFFF_FFFF); write_reg(REG_RA_ALIGN, 16'd0);
                         span = 32'h1000_0000; end
                3: begin write_reg(REG_POOL_BASE, 32'h100); write_reg(REG_POOL_BYTES, 32'd1000);
                         write_reg(REG_PROT_BYTES, 32'd100); write_reg(REG_RA_ALIGN, 16'd3);
                         write_reg(REG_RA_ALLOWP, 32'd1); span = 80; end
                default: begin write_reg(REG_POOL_BYTES, 32'd0); span = 10; end
            endcase
            quiet_phase = (ph == 3);
            for (int n = 0; n < N_RAND / 5; n++) begin
                it = random_request(span);
                send_item(it, 0, '0);
                if (ph == 0 && n == 100) while (pending_results.size() != 0) @(posedge i_clk);
            end
            quiet_phase = 1'b0;
            wait_drained();
        end

        if (n_errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #100000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ffra_pkg.sv
rtl/core/ffra_ram.sv
rtl/core/ffra_rndup.sv
rtl/core/ffra_regs.sv
rtl/core/first_fit_region_allocator_top.sv
sim/tb_first_fit_region_allocator_top.sv
